### hw/rtl/hdt_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the heading tracker.
// Used by hdt_ctrl, hdt_datapath and heading_tracker_top; depends on nothing else.
`timescale 1ns / 1ps

package hdt_pkg;

    // Default parameter values
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Width of the CORDIC x/y registers: 33-bit offsets grown by the CORDIC gain
    localparam int CORDIC_W = 36;

    // Configuration register indexes and reset values
    localparam logic CFG_TICK_PERIOD = 1'b0;
    localparam logic CFG_DEAD_ZONE   = 1'b1;
    localparam logic [15:0] TICK_PERIOD_RST = 16'd1092;
    localparam logic [15:0] DEAD_ZONE_RST   = 16'd7;

    // Quadrant pre-rotation offsets in 32-bit turn units
    localparam logic [31:0] TURN_QUARTER       = 32'h4000_0000;
    localparam logic [31:0] TURN_THREE_QUARTER = 32'hC000_0000;

    typedef enum logic [1:0] {
        CMD_SET_YAW = 2'd0,
        CMD_LOOK_AT = 2'd1,
        CMD_TICK    = 2'd2
    } t_command;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOK_DIFF,
        ST_LOOK_CHECK,
        ST_CORDIC,
        ST_LOOK_END,
        ST_TICK_GAIN,
        ST_TICK_MUL,
        ST_TICK_STEP,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic set_yaw;
        logic look_diff;
        logic look_load;
        logic cordic_step;
        logic look_end;
        logic tick_gain;
        logic tick_mul;
        logic tick_step;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_command cmd;
        logic     turning;
        logic     inside_dz;
        logic     cordic_last;
        logic     out_free;
    } t_dp_status;

    // atan(2^-i) in 32-bit turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/heading_tracker_top.sv
// Top level of the heading tracker: stream ports, configuration port,
// controller (hdt_ctrl) and datapath (hdt_datapath). Depends on hdt_pkg.
//
//  channel   direction  handshake                       payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata 160 bits, tuser = command
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata 24 bits
//  cfg       in         i_cfg_we                        i_cfg_addr, i_cfg_wdata
//
// One transaction at a time; the input is ready only while the controller is idle.
// Per transaction: set_yaw, an unused command and a tick while not turning go from
// dispatch to emit; a tick while turning passes gain, multiply and step (two multiplies
// in series); look_at forms offsets, tests the dead zone and emits at once if inside,
// else runs the CORDIC loop at one iteration per cycle. A result waits in the output
// register while the next transaction is taken; the emit step stalls until it is free.
// Reset is synchronous, active low, and loads yaw, goal and turning to zero.
`timescale 1ns / 1ps

module heading_tracker_top #(
    parameter int ANGLE_BITS   = hdt_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = hdt_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // new_yaw[15:0], target_x[47:16], target_z[79:48], own_x[111:80],
    // own_z[143:112], turn_rate[159:144]
    input  logic [159:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    // output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // yaw_now[15:0], turning_now[16], settled[17], zero[23:18]
    output logic [23:0]  o_m_axis_tdata
);
    import hdt_pkg::*;

    t_dp_cmd     w_cmd;
    t_dp_status  w_status;
    logic [15:0] w_yaw_now;
    logic        w_turning_now;

    hdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    hdt_datapath #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_s_axis_tuser),
        .i_new_yaw     (i_s_axis_tdata[15:0]),
        .i_target_x    (i_s_axis_tdata[47:16]),
        .i_target_z    (i_s_axis_tdata[79:48]),
        .i_own_x       (i_s_axis_tdata[111:80]),
        .i_own_z       (i_s_axis_tdata[143:112]),
        .i_turn_rate   (i_s_axis_tdata[159:144]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_yaw_now     (w_yaw_now),
        .o_turning_now (w_turning_now),
        .i_cmd         (w_cmd),
        .o_status      (w_status)
    );

    // Pack the result; settled is the inverse of turning
    assign o_m_axis_tdata = {6'd0, ~w_turning_now, w_turning_now, w_yaw_now};

endmodule

### hw/rtl/hdt_ctrl.sv
// Sequencing state machine of the heading tracker.
// Depends on hdt_pkg; drives hdt_datapath through t_dp_cmd and reads t_dp_status.
`timescale 1ns / 1ps

module hdt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hdt_pkg::t_dp_status i_status,
    output hdt_pkg::t_dp_cmd    o_cmd
);
    import hdt_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through the command sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_status.cmd)
                    CMD_LOOK_AT: n_state = ST_LOOK_DIFF;
                    CMD_TICK:    n_state = i_status.turning ? ST_TICK_GAIN : ST_EMIT;
                    default:     n_state = ST_EMIT;
                endcase
            end
            ST_LOOK_DIFF:  n_state = ST_LOOK_CHECK;
            ST_LOOK_CHECK: n_state = i_status.inside_dz ? ST_EMIT : ST_CORDIC;
            ST_CORDIC: begin
                if (i_status.cordic_last) n_state = ST_LOOK_END;
            end
            ST_LOOK_END:   n_state = ST_EMIT;
            ST_TICK_GAIN:  n_state = ST_TICK_MUL;
            ST_TICK_MUL:   n_state = ST_TICK_STEP;
            ST_TICK_STEP:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // Decode datapath commands from the state; refuse transactions while in reset
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            ST_DISPATCH:   o_cmd.set_yaw     = (i_status.cmd == CMD_SET_YAW);
            ST_LOOK_DIFF:  o_cmd.look_diff   = 1'b1;
            ST_LOOK_CHECK: o_cmd.look_load   = 1'b1;
            ST_CORDIC:     o_cmd.cordic_step = 1'b1;
            ST_LOOK_END:   o_cmd.look_end    = 1'b1;
            ST_TICK_GAIN:  o_cmd.tick_gain   = 1'b1;
            ST_TICK_MUL:   o_cmd.tick_mul    = 1'b1;
            ST_TICK_STEP:  o_cmd.tick_step   = 1'b1;
            ST_EMIT:       o_cmd.emit        = i_status.out_free;
            default:       o_cmd             = '0;
        endcase
    end

endmodule

### hw/rtl/hdt_datapath.sv
// Datapath of the heading tracker: input capture, configuration registers, yaw state,
// CORDIC atan2 unit, tick multipliers and output register. Depends on hdt_pkg.
`timescale 1ns / 1ps

module hdt_datapath #(
    parameter int ANGLE_BITS   = hdt_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = hdt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [15:0]         i_cfg_wdata,
    // input fields
    input  logic [1:0]          i_command,
    input  logic [15:0]         i_new_yaw,
    input  logic [31:0]         i_target_x,
    input  logic [31:0]         i_target_z,
    input  logic [31:0]         i_own_x,
    input  logic [31:0]         i_own_z,
    input  logic [15:0]         i_turn_rate,
    // output register
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [15:0]         o_yaw_now,
    output logic                o_turning_now,
    // control
    input  hdt_pkg::t_dp_cmd    i_cmd,
    output hdt_pkg::t_dp_status o_status
);
    import hdt_pkg::*;

    localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PROD_W = ANGLE_BITS + 32;
    localparam int STEP_W = PROD_W - 23;
    localparam logic [ITER_W-1:0] ITER_LAST  = ITER_W'(CORDIC_STEPS - 1);
    localparam logic [31:0]       ROUND_HALF = 32'd1 << (31 - ANGLE_BITS);
    localparam logic [PROD_W:0]   STEP_HALF  = {{(PROD_W - 23){1'b0}}, 1'b1, 23'd0};

    // configuration
    logic [15:0] r_tick_period;
    logic [15:0] r_dead_zone;

    // captured transaction
    logic [1:0]  r_command;
    logic [15:0] r_new_yaw;
    logic [31:0] r_target_x;
    logic [31:0] r_target_z;
    logic [31:0] r_own_x;
    logic [31:0] r_own_z;
    logic [15:0] r_turn_rate;

    // tracker state
    logic [ANGLE_BITS-1:0] r_yaw;
    logic [ANGLE_BITS-1:0] r_goal;
    logic                  r_turning;

    // look_at working registers
    logic signed [32:0]         r_dx;
    logic signed [32:0]         r_dz;
    logic signed [CORDIC_W-1:0] r_cx;
    logic signed [CORDIC_W-1:0] r_cy;
    logic [31:0]                r_cz;
    logic [ITER_W-1:0]          r_iter;

    // tick working registers
    logic [ANGLE_BITS-1:0] r_dmag;
    logic                  r_neg;
    logic [31:0]           r_k;
    logic [PROD_W-1:0]     r_prod;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_yaw;
    logic        r_out_turning;

    logic [32:0]                w_mag_dx;
    logic [32:0]                w_mag_dz;
    logic                       w_inside;
    logic signed [CORDIC_W-1:0] w_dx_ext;
    logic signed [CORDIC_W-1:0] w_dz_ext;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    logic [31:0]                w_atan;
    logic [31:0]                w_round;
    logic [ANGLE_BITS-1:0]      w_diff;
    logic [PROD_W:0]            w_sum;
    logic [STEP_W-1:0]          w_step;
    logic                       w_snap;
    logic                       w_out_free;

    // Dead-zone test on the offsets
    assign w_mag_dx = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign w_mag_dz = r_dz[32] ? 33'(-r_dz) : 33'(r_dz);
    assign w_inside = (w_mag_dx < {17'd0, r_dead_zone}) && (w_mag_dz < {17'd0, r_dead_zone});
    assign w_dx_ext = CORDIC_W'(r_dx);
    assign w_dz_ext = CORDIC_W'(r_dz);

    // One CORDIC vectoring iteration
    assign w_xs    = r_cx >>> r_iter;
    assign w_ys    = r_cy >>> r_iter;
    assign w_atan  = atan_turn(5'(r_iter));
    assign w_round = r_cz + ROUND_HALF;

    // Tick step, rounded half up
    assign w_diff = r_goal - r_yaw;
    assign w_sum  = {1'b0, r_prod} + STEP_HALF;
    assign w_step = w_sum[PROD_W:24];
    assign w_snap = (w_step >= STEP_W'(r_dmag));

    assign w_out_free = !r_out_valid || i_out_ready;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RST;
            r_dead_zone   <= DEAD_ZONE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TICK_PERIOD: r_tick_period <= i_cfg_wdata;
                CFG_DEAD_ZONE:   r_dead_zone   <= i_cfg_wdata;
                default:         r_dead_zone   <= r_dead_zone;
            endcase
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command   <= i_command;
            r_new_yaw   <= i_new_yaw;
            r_target_x  <= i_target_x;
            r_target_z  <= i_target_z;
            r_own_x     <= i_own_x;
            r_own_z     <= i_own_z;
            r_turn_rate <= i_turn_rate;
        end
    end

    // Update yaw, goal and turning flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw     <= '0;
            r_goal    <= '0;
            r_turning <= 1'b0;
        end else begin
            if (i_cmd.set_yaw) begin
                r_yaw <= ANGLE_BITS'(r_new_yaw);
            end
            if (i_cmd.look_end) begin
                r_goal    <= w_round[31 -: ANGLE_BITS];
                r_turning <= 1'b1;
            end
            if (i_cmd.tick_step) begin
                if (w_snap) begin
                    r_yaw     <= r_goal;
                    r_turning <= 1'b0;
                end else if (r_neg) begin
                    r_yaw <= r_yaw - w_step[ANGLE_BITS-1:0];
                end else begin
                    r_yaw <= r_yaw + w_step[ANGLE_BITS-1:0];
                end
            end
        end
    end

    // Form offsets, pre-rotate and iterate the CORDIC unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.look_diff) begin
            r_dx <= {r_target_x[31], r_target_x} - {r_own_x[31], r_own_x};
            r_dz <= {r_target_z[31], r_target_z} - {r_own_z[31], r_own_z};
        end
        if (i_cmd.look_load) begin
            r_iter <= '0;
            if (!r_dz[32]) begin
                r_cx <= w_dz_ext;
                r_cy <= w_dx_ext;
                r_cz <= '0;
            end else if (!r_dx[32]) begin
                r_cx <= w_dx_ext;
                r_cy <= -w_dz_ext;
                r_cz <= TURN_QUARTER;
            end else begin
                r_cx <= -w_dx_ext;
                r_cy <= w_dz_ext;
                r_cz <= TURN_THREE_QUARTER;
            end
        end
        if (i_cmd.cordic_step) begin
            r_iter <= r_iter + 1'b1;
            if (!r_cy[CORDIC_W-1]) begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end else begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end
        end
    end

    // Tick gain and scaled difference, one multiply per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_gain) begin
            r_k    <= 32'(r_tick_period) * 32'(r_turn_rate);
            r_neg  <= w_diff[ANGLE_BITS-1];
            r_dmag <= w_diff[ANGLE_BITS-1] ? (ANGLE_BITS'(0) - w_diff) : w_diff;
        end
        if (i_cmd.tick_mul) begin
            r_prod <= PROD_W'(r_dmag) * PROD_W'(r_k);
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_yaw     <= 16'(r_yaw);
            r_out_turning <= r_turning;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_yaw_now     = r_out_yaw;
    assign o_turning_now = r_out_turning;

    assign o_status.cmd         = t_command'(r_command);
    assign o_status.turning     = r_turning;
    assign o_status.inside_dz   = w_inside;
    assign o_status.cordic_last = (r_iter == ITER_LAST);
    assign o_status.out_free    = w_out_free;

    // A result is loaded only when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result loaded over an untaken result");

    // A snapping tick lands exactly on the goal and stops turning
    a_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick_step && w_snap) |=> (r_yaw == $past(r_goal) && !r_turning))
        else $error("tick snap did not reach goal");

    // A completed atan2 always starts a turn
    a_look_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.look_end |=> r_turning)
        else $error("look_at did not start turning");

    // CORDIC iterations stay inside the configured count
    a_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cordic_step |-> (r_iter <= ITER_LAST))
        else $error("CORDIC iteration count overrun");

endmodule
